### rtl/bpm_pkg.sv
`timescale 1ns / 1ps
package bpm_pkg;
  localparam int MaxCorpus     = 65536;
  localparam int MaxVocab      = 4096;
  localparam int MaxTokenLen   = 32;
  localparam int MaxTableSlots = 262144;
  localparam int SeqAw  = 16;
  localparam int SlotAw = 18;
  localparam int IdW    = 12;
  localparam int LenW   = 17;
  localparam int CntW   = 17;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [2:0] StMerged  = 3'd0;
  localparam logic [2:0] StTarget  = 3'd1;
  localparam logic [2:0] StShort   = 3'd2;
  localparam logic [2:0] StNoPair  = 3'd3;
  localparam logic [2:0] StTooLong = 3'd4;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdStep = 1'b1;

  // table entry: valid tag, key (two ids), count
  typedef struct packed {
    logic            used;
    logic [IdW-1:0]  left;
    logic [IdW-1:0]  right;
    logic [CntW-1:0] cnt;
  } slot_t;
  localparam int SlotW = $bits(slot_t);

  // start slot for a pair key
  function automatic logic [SlotAw-1:0] hash_slot(input logic [IdW-1:0] l,
                                                   input logic [IdW-1:0] r,
                                                   input logic [22:0] mask);
    logic [31:0] key;
    logic [31:0] mixed;
    logic [63:0] h;
    key   = {l, 20'd0} | {20'd0, r};
    mixed = key ^ (key >> 16);
    h     = {32'd0, mixed} * 64'h9E37_79B1;
    return SlotAw'(h[22:0] & mask);
  endfunction
endpackage

### rtl/bpm_ram.sv
`timescale 1ns / 1ps
module bpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/byte_pair_merge_trainer.sv
`timescale 1ns / 1ps
// Load beats are taken one per cycle while the block is idle. A step beat runs a
// sequencer: table clear, pair count with linear probing, table scan, length
// check, rewrite of the token sequence, then a flush of an unmerged last token;
// a stop found at the start is answered without any of these passes.
// Input stalls while a result beat waits. rst_n is synchronous: length 0,
// vocabulary 256, no stop, tables not cleared (each step clears its own table).
module byte_pair_merge_trainer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] corpus_byte
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [11:0] left id, [23:12] right id, [35:24] new id
  output logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLR   = 11'b00000000010,
    S_RD0   = 11'b00000000100,
    S_RD1   = 11'b00000001000,
    S_PRB   = 11'b00000010000,
    S_PCHK  = 11'b00000100000,
    S_SCAN  = 11'b00001000000,
    S_LEN   = 11'b00010000000,
    S_RW    = 11'b00100000000,
    S_RWCHK = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [12:0] target_r;
  logic [bpm_pkg::LenW-1:0] len_r, len_nxt;
  logic [12:0] vocab_r, vocab_nxt;
  logic [22:0] slots_r, slots_nxt;
  logic started_r, started_nxt;
  logic [2:0] stop_r, stop_nxt;
  logic [23:0] i_r, i_nxt;      // general index
  logic [22:0] n_r, n_nxt;      // probe count
  logic [bpm_pkg::IdW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [bpm_pkg::SlotAw-1:0] p_r, p_nxt;
  logic [bpm_pkg::LenW-1:0] w_r, w_nxt;
  logic [bpm_pkg::CntW-1:0] best_r, best_nxt;
  logic [bpm_pkg::IdW-1:0] bl_r, bl_nxt, br_r, br_nxt;
  logic found_r, found_nxt, half_r, half_nxt;
  logic [5:0] la_r, la_nxt;
  logic [38:0] out_r, out_nxt;
  logic ov_r, ov_nxt;

  // token memory
  logic seq_we;
  logic [bpm_pkg::SeqAw-1:0] seq_wa, seq_ra;
  logic [bpm_pkg::IdW-1:0] seq_wd, seq_rd;
  bpm_ram #(.Width(bpm_pkg::IdW), .Depth(bpm_pkg::MaxCorpus)) u_seq (
    .clk(clk), .we(seq_we), .waddr(seq_wa), .wdata(seq_wd), .raddr(seq_ra),
    .rdata(seq_rd));
  // pair table
  logic tab_we;
  logic [bpm_pkg::SlotAw-1:0] tab_wa, tab_ra;
  bpm_pkg::slot_t tab_wd, tab_rd;
  bpm_ram #(.Width(bpm_pkg::SlotW), .Depth(bpm_pkg::MaxTableSlots)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_wa), .wdata(tab_wd), .raddr(tab_ra),
    .rdata(tab_rd));
  // token lengths; entries above 255 written before read
  logic tl_we;
  logic [11:0] tl_wa, tl_ra;
  logic [5:0] tl_wd, tl_rd_m, tl_rd;
  logic tl_base_r;
  bpm_ram #(.Width(6), .Depth(bpm_pkg::MaxVocab)) u_tl (
    .clk(clk), .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(tl_ra),
    .rdata(tl_rd_m));
  assign tl_rd = tl_base_r ? 6'd1 : tl_rd_m;

  logic [12:0] cap, mcap;
  logic [22:0] mask;
  logic in_acc;
  logic [22:0] sc;

  assign in_tready  = (state_r == S_IDLE) && !(ov_r && !out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, out_r[38:3]};
  assign out_tuser  = out_r[2:0];
  assign cfg_ready  = 1'b1;
  assign mask       = slots_r - 23'd1;

  always_comb begin
    cap = (target_r < 13'd256) ? 13'd256 :
          (target_r > 13'(bpm_pkg::MaxVocab)) ? 13'(bpm_pkg::MaxVocab) : target_r;
    mcap = (cap - 13'd256 < 13'd1) ? 13'd1 : cap - 13'd256;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; len_nxt = len_r; vocab_nxt = vocab_r;
    slots_nxt = slots_r; started_nxt = started_r; stop_nxt = stop_r;
    i_nxt = i_r; n_nxt = n_r; a_nxt = a_r; b_nxt = b_r; p_nxt = p_r;
    w_nxt = w_r; best_nxt = best_r; bl_nxt = bl_r; br_nxt = br_r;
    found_nxt = found_r; half_nxt = half_r; la_nxt = la_r;
    out_nxt = out_r; ov_nxt = ov_r && !out_tready;
    seq_we = 1'b0; seq_wa = w_r[bpm_pkg::SeqAw-1:0]; seq_wd = a_r;
    seq_ra = i_r[bpm_pkg::SeqAw-1:0];
    tab_we = 1'b0; tab_wa = p_r; tab_wd = tab_rd; tab_ra = p_r;
    tl_we = 1'b0; tl_wa = vocab_r[11:0]; tl_wd = 6'd0; tl_ra = a_r;
    sc = 23'd1024;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == bpm_pkg::CmdLoad) begin
            if (!started_r && len_r < bpm_pkg::LenW'(bpm_pkg::MaxCorpus)) begin
              seq_we = 1'b1; seq_wa = len_r[bpm_pkg::SeqAw-1:0];
              seq_wd = {4'd0, in_tdata};
              len_nxt = len_r + 1'b1;
            end
          end else begin
            if (!started_r) begin
              started_nxt = 1'b1;
              sc = 23'd1024;
              for (int k = 0; k < 8; k++)
                if ({3'd0, sc} < {len_r, 2'b00} && sc < 23'(1 << 22) &&
                    {sc, 1'b0} <= 24'(bpm_pkg::MaxTableSlots))
                  sc = {sc[21:0], 1'b0};
              slots_nxt = sc;
            end
            out_nxt = 39'd0;
            if (stop_r != bpm_pkg::StMerged) begin
              out_nxt[2:0] = stop_r; state_nxt = S_OUT;
            end else if (vocab_r - 13'd256 >= mcap) begin
              stop_nxt = bpm_pkg::StTarget; out_nxt[2:0] = bpm_pkg::StTarget;
              state_nxt = S_OUT;
            end else if (len_r < 2) begin
              stop_nxt = bpm_pkg::StShort; out_nxt[2:0] = bpm_pkg::StShort;
              state_nxt = S_OUT;
            end else begin
              i_nxt = 24'd0; state_nxt = S_CLR;
            end
          end
        end
      end
      S_CLR: begin
        tab_we = 1'b1; tab_wa = i_r[bpm_pkg::SlotAw-1:0]; tab_wd = '0;
        if (i_r[22:0] == slots_r - 23'd1) begin
          i_nxt = 24'd0; state_nxt = S_RD0;
        end else i_nxt = i_r + 1'b1;
      end
      S_RD0: begin
        // pipe: read token i, then i+1
        seq_ra = i_r[bpm_pkg::SeqAw-1:0];
        half_nxt = 1'b0; state_nxt = S_RD1;
      end
      S_RD1: begin
        if (!half_r) begin
          a_nxt = seq_rd; half_nxt = 1'b1;
          seq_ra = bpm_pkg::SeqAw'(i_r + 1'b1);
        end else begin
          b_nxt = seq_rd;
          p_nxt = bpm_pkg::hash_slot(a_r, seq_rd, mask);
          n_nxt = 23'd0; state_nxt = S_PRB;
        end
      end
      S_PRB: begin
        tab_ra = p_r; state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!tab_rd.used || (tab_rd.left == a_r && tab_rd.right == b_r)) begin
          tab_we = 1'b1;
          tab_wd.used = 1'b1; tab_wd.left = a_r; tab_wd.right = b_r;
          tab_wd.cnt = !tab_rd.used ? bpm_pkg::CntW'(1) :
                       (tab_rd.cnt == bpm_pkg::CntMax) ? tab_rd.cnt : tab_rd.cnt + 1'b1;
          n_nxt = slots_r;
        end else begin
          n_nxt = n_r + 1'b1;
          p_nxt = bpm_pkg::SlotAw'((23'(p_r) + 23'd1) & mask);
        end
        if (n_nxt == slots_r) begin
          if (i_r + 24'd2 >= 24'(len_r)) begin
            i_nxt = 24'd0; best_nxt = bpm_pkg::CntW'(1); found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            i_nxt = i_r + 1'b1; state_nxt = S_RD0;
          end
        end else state_nxt = S_PRB;
      end
      S_SCAN: begin
        // address i issued, data for i-1 checked
        tab_ra = i_r[bpm_pkg::SlotAw-1:0];
        if (i_r != 0 && tab_rd.used && tab_rd.cnt > best_r) begin
          best_nxt = tab_rd.cnt; bl_nxt = tab_rd.left; br_nxt = tab_rd.right;
          found_nxt = 1'b1;
        end
        if (i_r[22:0] == slots_r) begin
          if (!found_nxt) begin
            stop_nxt = bpm_pkg::StNoPair; out_nxt[2:0] = bpm_pkg::StNoPair;
            state_nxt = S_OUT;
          end else begin
            half_nxt = 1'b0; state_nxt = S_LEN;
          end
        end else i_nxt = i_r + 1'b1;
      end
      S_LEN: begin
        if (!half_r) begin
          tl_ra = bl_r; half_nxt = 1'b1; la_nxt = 6'd0;
          n_nxt = 23'd0;
        end else if (n_r == 0) begin
          la_nxt = tl_rd; tl_ra = br_r; n_nxt = 23'd1;
        end else if (n_r == 1) begin
          // keep the right id on the read port
          tl_ra = br_r; n_nxt = 23'd2;
        end else begin
          if (7'(la_r) + 7'(tl_rd) > 7'(bpm_pkg::MaxTokenLen)) begin
            stop_nxt = bpm_pkg::StTooLong; out_nxt[2:0] = bpm_pkg::StTooLong;
            state_nxt = S_OUT;
          end else if (vocab_r >= cap) begin
            stop_nxt = bpm_pkg::StTarget; out_nxt[2:0] = bpm_pkg::StTarget;
            state_nxt = S_OUT;
          end else begin
            tl_we = 1'b1; tl_wd = 6'(la_r + tl_rd);
            out_nxt = {vocab_r[11:0], br_r, bl_r, bpm_pkg::StMerged};
            vocab_nxt = vocab_r + 1'b1;
            i_nxt = 24'd0; w_nxt = '0; half_nxt = 1'b0;
            state_nxt = S_RW;
          end
        end
      end
      S_RW: begin
        // a_r holds token i-1 once half_r is set
        seq_ra = i_r[bpm_pkg::SeqAw-1:0];
        state_nxt = S_RWCHK;
      end
      S_RWCHK: begin
        if (!half_r) begin
          a_nxt = seq_rd; half_nxt = 1'b1;
          if (i_r + 24'd1 < 24'(len_r)) begin
            i_nxt = i_r + 1'b1; state_nxt = S_RW;
          end else begin
            seq_we = 1'b1; seq_wd = seq_rd; w_nxt = w_r + 1'b1;
            len_nxt = w_r + 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
          end
        end else begin
          // a_r = token i-1, seq_rd = token i
          if (a_r == bl_r && seq_rd == br_r) begin
            seq_we = 1'b1; seq_wd = out_r[38:27]; w_nxt = w_r + 1'b1;
            half_nxt = 1'b0;
            if (i_r + 24'd1 < 24'(len_r)) begin
              i_nxt = i_r + 1'b1; state_nxt = S_RW;
            end else begin
              len_nxt = w_r + 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
            end
          end else begin
            seq_we = 1'b1; seq_wd = a_r; w_nxt = w_r + 1'b1; a_nxt = seq_rd;
            if (i_r + 24'd1 < 24'(len_r)) begin
              i_nxt = i_r + 1'b1; state_nxt = S_RW;
            end else begin
              state_nxt = S_OUT; // flush last token next
              half_nxt = 1'b1;
            end
          end
        end
      end
      S_OUT: begin
        if (out_r[2:0] == bpm_pkg::StMerged && half_r) begin
          seq_we = 1'b1; seq_wd = a_r; len_nxt = w_r + 1'b1; half_nxt = 1'b0;
        end
        if (!(ov_r && !out_tready)) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; target_r <= 13'd4096; len_r <= '0; vocab_r <= 13'd256;
      slots_r <= 23'd1024; started_r <= 1'b0; stop_r <= bpm_pkg::StMerged;
      ov_r <= 1'b0; half_r <= 1'b0; tl_base_r <= 1'b0;
    end else begin
      state_r <= state_nxt; len_r <= len_nxt; vocab_r <= vocab_nxt;
      slots_r <= slots_nxt; started_r <= started_nxt; stop_r <= stop_nxt;
      ov_r <= ov_nxt; half_r <= half_nxt;
      tl_base_r <= (tl_ra < 12'd256);
      if (cfg_valid) target_r <= cfg_data;
    end
    i_r <= i_nxt; n_r <= n_nxt; a_r <= a_nxt; b_r <= b_nxt; p_r <= p_nxt;
    w_r <= w_nxt; best_r <= best_nxt; bl_r <= bl_nxt; br_r <= br_nxt;
    found_r <= found_nxt; la_r <= la_nxt; out_r <= out_nxt;
  end
endmodule

### rtl/bpm_checker.sv
`timescale 1ns / 1ps
module bpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser
);
  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input changed while stalled");
  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");
  // status within range
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= bpm_pkg::StTooLong)
    else $error("bad status");
  // ids zero unless merged
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != bpm_pkg::StMerged |-> out_tdata[35:0] == 36'd0)
    else $error("ids on stop");
  // merged id is a new one
  a_newid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bpm_pkg::StMerged |-> out_tdata[35:24] >= 12'd256)
    else $error("new id below base");
endmodule

bind byte_pair_merge_trainer bpm_checker u_bpm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .in_tuser(in_tuser), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser));

### dv/byte_pair_merge_trainer_tb.sv
`timescale 1ns / 1ps
module byte_pair_merge_trainer_tb;

  localparam int Idle_Limit  = 400000;
  localparam int Cfg_Quiet   = 40;
  localparam int Load_Beats  = 300;
  localparam int Step_Beats  = 1000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_data;

  typedef struct packed {
    logic            is_cfg;
    logic [12:0]     vocab_target;
    logic            cmd;
    logic [7:0]      corpus_byte;
  } pending_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [bpm_pkg::IdW-1:0] left_id;
    logic [bpm_pkg::IdW-1:0] rgt_id;
    logic [bpm_pkg::IdW-1:0] new_id;
  } merge_res_t;

  pending_t   beat_queue[$];
  merge_res_t owed_results[$];

  // shadow copy of the trainer state
  logic [bpm_pkg::IdW-1:0] tok_seq [bpm_pkg::MaxCorpus];
  int unsigned     seq_len;
  int unsigned     pair_key [bpm_pkg::MaxTableSlots];
  int unsigned     pair_cnt [bpm_pkg::MaxTableSlots];
  bit              pair_used[bpm_pkg::MaxTableSlots];
  int unsigned     tok_len  [bpm_pkg::MaxVocab];
  int unsigned     vocab_cnt;
  int unsigned     n_slots;
  bit              started;
  logic [2:0]      stop_code;
  int unsigned     vocab_target;

  int errors, n_merged, n_stopped, n_ignored, n_cfg, n_results;
  int gap, quiet, hold, idle_cycles;
  bit no_gap_mode;

  byte_pair_merge_trainer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // count one adjacent pair into the probe table
  function automatic void tally(input int unsigned key);
    logic [63:0] h;
    int unsigned idx;
    h   = 64'(key ^ (key >> 16)) * 64'h9E37_79B1;
    idx = h[31:0] & (n_slots - 1);
    for (int n = 0; n < n_slots; n++) begin
      if (!pair_used[idx]) begin
        pair_used[idx] = 1'b1;
        pair_key[idx]  = key;
        pair_cnt[idx]  = 1;
        return;
      end
      if (pair_key[idx] == key) begin
        if (pair_cnt[idx] < bpm_pkg::CntMax) pair_cnt[idx]++;
        return;
      end
      idx = (idx + 1) & (n_slots - 1);
    end
  endfunction

  // one merge on the shadow state
  function automatic merge_res_t merge_step();
    merge_res_t  res;
    int unsigned cap, mcap, best, bkey, lft, rgt, comb, w, i;
    bit          found;
    res   = '0;
    best  = 1;
    bkey  = 0;
    found = 1'b0;
    cap = vocab_target;
    if (cap < 256) cap = 256;
    if (cap > bpm_pkg::MaxVocab) cap = bpm_pkg::MaxVocab;
    mcap = cap - 256;
    if (mcap < 1) mcap = 1;
    if (vocab_cnt - 256 >= mcap) begin
      res.status = bpm_pkg::StTarget;
      return res;
    end
    if (seq_len < 2) begin
      res.status = bpm_pkg::StShort;
      return res;
    end
    for (i = 0; i < n_slots; i++) pair_used[i] = 1'b0;
    for (i = 0; i + 1 < seq_len; i++) tally({tok_seq[i], 8'h00, tok_seq[i+1]});
    for (i = 0; i < n_slots; i++) begin
      if (pair_used[i] && pair_cnt[i] > best) begin
        best  = pair_cnt[i];
        bkey  = pair_key[i];
        found = 1'b1;
      end
    end
    if (!found) begin
      res.status = bpm_pkg::StNoPair;
      return res;
    end
    lft  = (bkey >> 20) & 12'hFFF;
    rgt  = bkey & 12'hFFF;
    comb = tok_len[lft] + tok_len[rgt];
    if (comb > bpm_pkg::MaxTokenLen) begin
      res.status = bpm_pkg::StTooLong;
      return res;
    end
    if (vocab_cnt >= cap) begin
      res.status = bpm_pkg::StTarget;
      return res;
    end
    tok_len[vocab_cnt % bpm_pkg::MaxVocab] = comb;
    // rewrite left to right, non-overlapping
    w = 0;
    i = 0;
    while (i < seq_len) begin
      if (i + 1 < seq_len && tok_seq[i] == lft && tok_seq[i+1] == rgt) begin
        tok_seq[w] = bpm_pkg::IdW'(vocab_cnt);
        i += 2;
      end else begin
        tok_seq[w] = tok_seq[i];
        i += 1;
      end
      w++;
    end
    seq_len       = w;
    res.status    = bpm_pkg::StMerged;
    res.left_id   = bpm_pkg::IdW'(lft);
    res.rgt_id    = bpm_pkg::IdW'(rgt);
    res.new_id    = bpm_pkg::IdW'(vocab_cnt);
    vocab_cnt++;
    return res;
  endfunction

  // predict what one accepted input beat causes
  function automatic void accept_beat(input logic c, input logic [7:0] d);
    merge_res_t res;
    res = '0;
    if (c == bpm_pkg::CmdLoad) begin
      if (!started && seq_len < bpm_pkg::MaxCorpus) begin
        tok_seq[seq_len] = bpm_pkg::IdW'(d);
        seq_len++;
      end else begin
        n_ignored++;
      end
      return;
    end
    if (!started) begin
      started = 1'b1;
      n_slots = 1024;
      while (n_slots < seq_len * 4 && n_slots < (1 << 22) &&
             n_slots * 2 <= bpm_pkg::MaxTableSlots)
        n_slots *= 2;
    end
    if (stop_code != bpm_pkg::StMerged) begin
      res.status = stop_code;
    end else begin
      res = merge_step();
      stop_code = res.status;
    end
    owed_results.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_gap_mode || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // driver: input beats and register writes; shadow state follows reset
  always @(posedge clk) begin
    logic nv_in, nv_cfg;
    pending_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      cfg_data  <= '0;
      gap   = 0;
      quiet = 0;
      seq_len      = 0;
      vocab_cnt    = 256;
      n_slots      = 1024;
      started      = 1'b0;
      stop_code    = bpm_pkg::StMerged;
      vocab_target = 4096;
      for (int i = 0; i < bpm_pkg::MaxVocab; i++) tok_len[i] = (i < 256) ? 1 : 0;
    end else begin
      if (in_tvalid && in_tready) accept_beat(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) begin
        vocab_target = cfg_data;
        n_cfg++;
      end
      quiet  = (owed_results.size() != 0 || (in_tvalid && in_tready)) ? 0 : quiet + 1;
      nv_in  = in_tvalid && !in_tready;
      nv_cfg = cfg_valid && !cfg_ready;
      if (!nv_in && !nv_cfg) begin
        if (gap > 0) begin
          gap--;
        end else if (beat_queue.size() > 0) begin
          p = beat_queue[0];
          if (p.is_cfg) begin
            if (owed_results.size() == 0 && quiet >= Cfg_Quiet) begin
              cfg_data <= p.vocab_target;
              nv_cfg = 1'b1;
              void'(beat_queue.pop_front());
            end
          end else begin
            in_tdata <= p.corpus_byte;
            in_tuser <= p.cmd;
            nv_in = 1'b1;
            void'(beat_queue.pop_front());
            gap = pick_gap();
            if ($urandom_range(0, 99) == 0) no_gap_mode = !no_gap_mode;
          end
        end
      end
      in_tvalid <= nv_in;
      cfg_valid <= nv_cfg;
    end
  end

  // monitor: result beats, receiver stalls
  always @(posedge clk) begin
    merge_res_t exp_r, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status   = out_tuser;
        got.left_id  = out_tdata[11:0];
        got.rgt_id   = out_tdata[23:12];
        got.new_id   = out_tdata[35:24];
        n_results++;
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          exp_r = owed_results.pop_front();
          if (got.status == bpm_pkg::StMerged) n_merged++;
          else n_stopped++;
          if (got.status !== exp_r.status)
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
          if (got.left_id !== exp_r.left_id)
            $display("%0t: left id exp %0d got %0d", $time, exp_r.left_id, got.left_id);
          if (got.rgt_id !== exp_r.rgt_id)
            $display("%0t: right id exp %0d got %0d", $time, exp_r.rgt_id, got.rgt_id);
          if (got.new_id !== exp_r.new_id)
            $display("%0t: new id exp %0d got %0d", $time, exp_r.new_id, got.new_id);
          if (got !== exp_r) errors++;
        end
        // long hold-off so that the input backs up behind a finished step
        if (n_results == 5 || n_results == 500) hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_gap_mode || ($urandom_range(0, 9) < 7);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= Idle_Limit) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("[byte_pair_merge_trainer] ERROR");
      $finish;
    end
  end

  function automatic void push_cfg(input logic [12:0] v);
    pending_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.vocab_target = v;
    beat_queue.push_back(p);
  endfunction

  function automatic void push_beat(input logic c, input logic [7:0] b);
    pending_t p;
    p = '0;
    p.cmd = c;
    p.corpus_byte = b;
    beat_queue.push_back(p);
  endfunction

  initial begin
    logic [7:0] alpha[6];
    int steps;
    rst_n = 1'b0;
    for (int i = 0; i < 6; i++) alpha[i] = 8'($urandom);
    alpha[0] = 8'h00;
    alpha[1] = 8'hFF;

    // above the vocabulary ceiling first
    push_cfg(13'h1FFF);
    // extreme bytes, then a long run of one byte for deep merges
    push_beat(bpm_pkg::CmdLoad, 8'h00);
    push_beat(bpm_pkg::CmdLoad, 8'hFF);
    push_beat(bpm_pkg::CmdLoad, 8'h55);
    push_beat(bpm_pkg::CmdLoad, 8'hAA);
    for (int i = 0; i < 64; i++) push_beat(bpm_pkg::CmdLoad, 8'h61);
    for (int i = 68; i < Load_Beats; i++)
      push_beat(bpm_pkg::CmdLoad,
                ($urandom_range(0, 9) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 5)]);

    // step phase with late loads mixed in as noise
    steps = 0;
    while (steps < Step_Beats) begin
      if ($urandom_range(0, 3) == 0) begin
        push_beat(bpm_pkg::CmdLoad, 8'($urandom));
      end else begin
        push_beat(bpm_pkg::CmdStep, 8'($urandom));
        steps++;
        if (steps == 60) push_cfg(13'd4096);
        if (steps == 150) push_cfg(13'($urandom_range(256, 500)));
        if (steps == 400) push_cfg(13'd0);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (beat_queue.size() == 0 && !in_tvalid && !cfg_valid && owed_results.size() == 0);
    repeat (500) @(posedge clk);

    $display("%0d step results (%0d merges, %0d stop reports), %0d late loads dropped,",
             n_results, n_merged, n_stopped, n_ignored);
    $display("%0d register writes, final vocabulary %0d, table %0d slots, stop code %0d",
             n_cfg, vocab_cnt, n_slots, stop_code);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("[byte_pair_merge_trainer] OK");
    end else begin
      $display("[byte_pair_merge_trainer] ERROR");
    end
    $finish;
  end

endmodule
